// ----- hdl/cpa_pkg.sv -----
package cpa_pkg;

    localparam int NUM_LANES = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd3;

endpackage

// ----- hdl/cpa_lane.sv -----
module cpa_lane #(
    parameter int CW = 32
) (
    input  logic                  clk,
    input  logic [CW-1:0]         pos,
    input  logic [CW-1:0]         center,
    input  logic [CW-1:0]         strength,
    output logic [2*(CW+1)-1:0]   sq,
    output logic [2*CW:0]         prod,
    output logic                  neg
);

    logic [CW:0]          d_reg;
    logic [CW:0]          mag;
    logic [2*(CW+1)-1:0]  sq_reg;
    logic [2*CW:0]        prod_reg;
    logic                 neg_reg;

    always_ff @(posedge clk)
    begin
        d_reg <= {pos[CW-1], pos} - {center[CW-1], center};
    end

    assign mag = d_reg[CW] ? (~d_reg + (CW+1)'(1)) : d_reg;

    always_ff @(posedge clk)
    begin
        sq_reg   <= (2*(CW+1))'(mag) * (2*(CW+1))'(mag);
        prod_reg <= (2*CW+1)'(strength) * (2*CW+1)'(mag);
        neg_reg  <= ~d_reg[CW];
    end

    assign sq   = sq_reg;
    assign prod = prod_reg;
    assign neg  = neg_reg;

endmodule

// ----- hdl/cpa_isqrt.sv -----
module cpa_isqrt #(
    parameter int ROOT_W = 34
) (
    input  logic                 clk,
    input  logic [2*ROOT_W-1:0]  radicand,
    output logic [ROOT_W-1:0]    root
);

    localparam int SUM_W = 2 * ROOT_W;

    logic [SUM_W-1:0]  rem_s  [1:ROOT_W];
    logic [ROOT_W-1:0] root_s [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W:0]    trial;

        if (k == 0)
        begin : g_head
            assign rem_in  = radicand;
            assign root_in = '0;
        end
        else
        begin : g_body
            assign rem_in  = rem_s[k];
            assign root_in = root_s[k];
        end

        assign trial = ((SUM_W+1)'(root_in) << (B + 1)) + ((SUM_W+1)'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if ({1'b0, rem_in} >= trial)
            begin
                rem_s[k+1]  <= SUM_W'({1'b0, rem_in} - trial);
                root_s[k+1] <= root_in | (ROOT_W'(1) << B);
            end
            else
            begin
                rem_s[k+1]  <= rem_in;
                root_s[k+1] <= root_in;
            end
        end
    end

    assign root = root_s[ROOT_W];

endmodule

// ----- hdl/cpa_div.sv -----
module cpa_div #(
    parameter int CW = 32
) (
    input  logic            clk,
    input  logic [2*CW:0]   num,
    input  logic [CW+1:0]   den,
    input  logic            tag_in,
    output logic [CW-1:0]   quot,
    output logic            tag_out
);

    localparam int NUM_W = 2 * CW + 1;
    localparam int DEN_W = CW + 2;

    logic [NUM_W-1:0] rem_s [1:CW];
    logic [DEN_W-1:0] den_s [1:CW];
    logic [CW-1:0]    q_s   [1:CW];
    logic             tag_s [1:CW];

    for (genvar k = 0; k < CW; k++) begin : g_stage
        localparam int B = CW - 1 - k;
        logic [NUM_W-1:0]       rem_in;
        logic [DEN_W-1:0]       den_in;
        logic [CW-1:0]          q_in;
        logic                   tag_in_s;
        logic [NUM_W+DEN_W-1:0] dsh;

        if (k == 0)
        begin : g_head
            assign rem_in   = num;
            assign den_in   = den;
            assign q_in     = '0;
            assign tag_in_s = tag_in;
        end
        else
        begin : g_body
            assign rem_in   = rem_s[k];
            assign den_in   = den_s[k];
            assign q_in     = q_s[k];
            assign tag_in_s = tag_s[k];
        end

        assign dsh = (NUM_W+DEN_W)'(den_in) << B;

        always_ff @(posedge clk)
        begin
            den_s[k+1] <= den_in;
            tag_s[k+1] <= tag_in_s;
            if ((NUM_W+DEN_W)'(rem_in) >= dsh)
            begin
                rem_s[k+1] <= NUM_W'((NUM_W+DEN_W)'(rem_in) - dsh);
                q_s[k+1]   <= q_in | (CW'(1) << B);
            end
            else
            begin
                rem_s[k+1] <= rem_in;
                q_s[k+1]   <= q_in;
            end
        end
    end

    assign quot    = q_s[CW];
    assign tag_out = tag_s[CW];

endmodule

// ----- hdl/constant_pull_attractor_3d.sv -----
// Constant-magnitude point attractor, 3D.
// Command channel: an item (pos_x, pos_y, pos_z) is taken at a rising edge
// with start high and busy low. busy stays low, so one item per cycle.
// Result channel: accel_x/y/z and at_center appear for one cycle with done
// high once the item has passed through the pipeline stages:
// two lane stages, one sum stage, one square-root stage per root bit
// (COORD_WIDTH + 2), one divider stage per quotient bit (COORD_WIDTH) per
// lane, and the output register. Results leave in item order.
// Throughput is one item per cycle at any width.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// strength, 1..3 centre x/y/z; other indexes are ignored. cfg_ready is
// always high. Write only while no item is in flight.
// Reset clears the pipeline valid bits and loads strength 66 and a zero
// centre. The receiver cannot stall; done has no back-pressure.
module constant_pull_attractor_3d
    import cpa_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    output logic                         done,
    output logic signed [COORD_WIDTH:0]  accel_x,
    output logic signed [COORD_WIDTH:0]  accel_y,
    output logic signed [COORD_WIDTH:0]  accel_z,
    output logic                         at_center,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]       cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int ROOT_W = CW + 2;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int SQ_W   = 2 * (CW + 1);
    localparam int PROD_W = 2 * CW + 1;
    localparam int PDLY   = ROOT_W + 1;
    localparam int LAT    = 4 + ROOT_W + CW;

    logic [CW-1:0] strength_reg;
    logic [CW-1:0] center_x_reg;
    logic [CW-1:0] center_y_reg;
    logic [CW-1:0] center_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= CW'(66);
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STRENGTH: strength_reg <= cfg_data;
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    logic [CW-1:0]     pos_l  [NUM_LANES];
    logic [CW-1:0]     ctr_l  [NUM_LANES];
    logic [SQ_W-1:0]   sq_l   [NUM_LANES];
    logic [PROD_W-1:0] prod_l [NUM_LANES];
    logic              neg_l  [NUM_LANES];
    logic [CW-1:0]     q_l    [NUM_LANES];
    logic              qneg_l [NUM_LANES];
    logic [CW:0]       acc_l  [NUM_LANES];

    assign pos_l[0] = pos_x;
    assign pos_l[1] = pos_y;
    assign pos_l[2] = pos_z;
    assign ctr_l[0] = center_x_reg;
    assign ctr_l[1] = center_y_reg;
    assign ctr_l[2] = center_z_reg;

    logic [SUM_W-1:0]  sum_reg;
    logic [ROOT_W-1:0] root;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_front
        cpa_lane #(.CW(CW)) u_lane (
            .clk      (clk),
            .pos      (pos_l[g]),
            .center   (ctr_l[g]),
            .strength (strength_reg),
            .sq       (sq_l[g]),
            .prod     (prod_l[g]),
            .neg      (neg_l[g])
        );
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= SUM_W'(sq_l[0]) + SUM_W'(sq_l[1]) + SUM_W'(sq_l[2]);
    end

    cpa_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
        .clk      (clk),
        .radicand (sum_reg),
        .root     (root)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_back
        logic [PROD_W-1:0] pd_reg [PDLY];
        logic              nd_reg [PDLY];

        always_ff @(posedge clk)
        begin
            pd_reg[0] <= prod_l[g];
            nd_reg[0] <= neg_l[g];
        end

        for (genvar s = 1; s < PDLY; s++) begin : g_dly
            always_ff @(posedge clk)
            begin
                pd_reg[s] <= pd_reg[s-1];
                nd_reg[s] <= nd_reg[s-1];
            end
        end

        cpa_div #(.CW(CW)) u_div (
            .clk     (clk),
            .num     (pd_reg[PDLY-1]),
            .den     (root),
            .tag_in  (nd_reg[PDLY-1]),
            .quot    (q_l[g]),
            .tag_out (qneg_l[g])
        );
    end

    logic zd_reg [CW];

    always_ff @(posedge clk)
    begin
        zd_reg[0] <= (root == '0);
    end

    for (genvar s = 1; s < CW; s++) begin : g_zdly
        always_ff @(posedge clk)
        begin
            zd_reg[s] <= zd_reg[s-1];
        end
    end

    // merge lanes: drop the quotient at the centre, apply the pull direction
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (zd_reg[CW-1])
                acc_l[i] = '0;
            else if (qneg_l[i])
                acc_l[i] = (CW+1)'(0) - {1'b0, q_l[i]};
            else
                acc_l[i] = {1'b0, q_l[i]};
        end
    end

    logic [CW:0] accel_x_reg;
    logic [CW:0] accel_y_reg;
    logic [CW:0] accel_z_reg;
    logic        at_center_reg;

    always_ff @(posedge clk)
    begin
        accel_x_reg   <= acc_l[0];
        accel_y_reg   <= acc_l[1];
        accel_z_reg   <= acc_l[2];
        at_center_reg <= zd_reg[CW-1];
    end

    assign done      = vld_reg[LAT-1];
    assign accel_x   = accel_x_reg;
    assign accel_y   = accel_y_reg;
    assign accel_z   = accel_z_reg;
    assign at_center = at_center_reg;

endmodule
